FILE: src/bmo_pkg.sv
// Shared constants, types and helper functions of the box and mask overlay.
`default_nettype none
package bmo_pkg;

    localparam int MAX_BOXES  = 16;
    localparam int MAX_TRACKS = 16;
    localparam int MASK_CELLS = 4096;

    localparam int NCELL   = (MAX_BOXES > MAX_TRACKS) ? MAX_BOXES : MAX_TRACKS;
    localparam int BCNT_W  = $clog2(MAX_BOXES + 1);
    localparam int TCNT_W  = $clog2(MAX_TRACKS + 1);
    localparam int MASK_AW = $clog2(MASK_CELLS);

    localparam int PX_W   = 11;   // pixel coordinate
    localparam int DIM_W  = 12;   // frame dimension
    localparam int MDIM_W = 13;   // mask dimension
    localparam int Q_W    = 13;   // mask column or row
    localparam int NUM_W  = 24;   // coordinate times mask dimension
    localparam int IDX_W  = 27;   // flat mask address before range check
    localparam int COR_W  = 11;   // box or track corner
    localparam int MNUM_W = 18;   // Q1.17 corner numerator
    localparam int PROD_W = 30;   // numerator times dimension

    localparam logic [DIM_W-1:0] DIM_MAX = 12'd2048;
    localparam logic [11:0]      TRK_W   = 12'd30;
    localparam logic [11:0]      TRK_H   = 12'd10;
    localparam logic [24:0]      RECIP_10 = 25'd6554;

    // command codes
    localparam logic [2:0] CMD_NEW_FRAME = 3'd0;
    localparam logic [2:0] CMD_ADD_BOX   = 3'd1;
    localparam logic [2:0] CMD_ADD_TRACK = 3'd2;
    localparam logic [2:0] CMD_MASK_CELL = 3'd3;
    localparam logic [2:0] CMD_PIXEL     = 3'd4;

    // register indexes
    localparam logic [2:0] REG_FRAME_W   = 3'd0;
    localparam logic [2:0] REG_FRAME_H   = 3'd1;
    localparam logic [2:0] REG_MASK_W    = 3'd2;
    localparam logic [2:0] REG_MASK_H    = 3'd3;
    localparam logic [2:0] REG_DRAW_BOX  = 3'd4;
    localparam logic [2:0] REG_DRAW_MASK = 3'd5;

    // mask classes
    localparam logic [1:0] CLS_GREEN = 2'd0;
    localparam logic [1:0] CLS_RED   = 2'd1;
    localparam logic [1:0] CLS_NONE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WR,
        ST_PIX,
        ST_IDX,
        ST_RD,
        ST_OUT
    } bmo_state_t;

    typedef struct packed {
        logic            vld;
        logic [PX_W-1:0] x;
        logic [PX_W-1:0] y;
        logic            red;
        logic            black;
    } bmo_tok_t;

    typedef struct packed {
        logic [COR_W-1:0] c0;
        logic [COR_W-1:0] c1;
        logic [COR_W-1:0] c2;
        logic [COR_W-1:0] c3;
    } bmo_ent_t;

    typedef struct packed {
        logic box_we;
        logic trk_we;
        logic box_on;
        logic trk_on;
    } bmo_cellctl_t;

    // p within two of e
    function automatic logic bmo_near(input logic [PX_W-1:0] p, input logic [COR_W-1:0] e);
        logic [11:0] pe;
        logic [11:0] ee;
        begin
            pe = {1'b0, p};
            ee = {1'b0, e};
            return (pe + 12'd2 >= ee) && (pe <= ee + 12'd2);
        end
    endfunction

    // floor((7c + 3k) / 10) by reciprocal, exact for sums up to 2550
    function automatic logic [7:0] bmo_blend(input logic [7:0] c, input logic [7:0] k);
        logic [11:0] v;
        logic [24:0] m;
        begin
            v = ({4'b0, c} << 3) - {4'b0, c} + ({4'b0, k} << 1) + {4'b0, k};
            m = {13'b0, v} * RECIP_10;
            return m[23:16];
        end
    endfunction

    // clamp a scaled corner to [0, dim-1]
    function automatic logic [COR_W-1:0] bmo_clamp(input logic [12:0] v,
                                                   input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] dm1;
        begin
            dm1 = dim - 12'd1;
            if (dim == '0)
                return '0;
            else if (v > {1'b0, dm1})
                return dm1[COR_W-1:0];
            else
                return v[COR_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: src/bmo_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bmo_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: src/bmo_cell.sv
// One overlay cell: holds a box and a track, tests the passing pixel token.
`default_nettype none
module bmo_cell
    import bmo_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire bmo_cellctl_t ctl,
    input  wire bmo_ent_t     ent,
    input  wire bmo_tok_t     tok_in,
    output bmo_tok_t          tok_out
);

    logic [COR_W-1:0] bl_reg, br_reg, bt_reg, bb_reg;
    logic [COR_W-1:0] tl_reg, tt_reg;
    logic             tvld_reg;
    bmo_tok_t         tok_reg;
    logic [COR_W-1:0] ty;
    logic             nx, ny, red_hit, black_hit;

    always_ff @(posedge clk)
    begin
        if (ctl.box_we)
        begin
            bl_reg <= ent.c0;
            br_reg <= ent.c1;
            bt_reg <= ent.c2;
            bb_reg <= ent.c3;
        end
        if (ctl.trk_we)
        begin
            tl_reg <= ent.c0;
            tt_reg <= ent.c1;
        end
    end

    always_comb
    begin
        nx = bmo_near(tok_in.x, bl_reg) || bmo_near(tok_in.x, br_reg);
        ny = bmo_near(tok_in.y, bt_reg) || bmo_near(tok_in.y, bb_reg);
        red_hit = ctl.box_on &&
                  ((nx && tok_in.y >= bt_reg && tok_in.y <= bb_reg) ||
                   (ny && tok_in.x >= bl_reg && tok_in.x <= br_reg));
        ty = ({1'b0, tt_reg} >= TRK_H) ? COR_W'({1'b0, tt_reg} - TRK_H) : '0;
        black_hit = ctl.trk_on &&
                    tok_in.x >= tl_reg && {1'b0, tok_in.x} < {1'b0, tl_reg} + TRK_W &&
                    tok_in.y >= ty && {1'b0, tok_in.y} < {1'b0, ty} + TRK_H;
    end

    // advance the token one cell per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvld_reg <= 1'b0;
        end
        else
        begin
            tvld_reg <= tok_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg.x     <= tok_in.x;
        tok_reg.y     <= tok_in.y;
        tok_reg.red   <= tok_in.red || red_hit;
        tok_reg.black <= tok_in.black || black_hit;
        tok_reg.vld   <= 1'b0;
    end

    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.vld = tvld_reg;
    end

endmodule
`default_nettype wire

FILE: src/bmo_div.sv
// Restoring divider: 24-bit dividend over a 12-bit divisor, 13 quotient bits.
`default_nettype none
module bmo_div
    import bmo_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DIM_W-1:0] den,
    output logic                  busy,
    output logic      [Q_W-1:0]   quot
);

    logic [PX_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]  lo_reg, lo_next;
    logic [Q_W-1:0]  quo_reg, quo_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [DIM_W-1:0] trial;
    logic             take;

    always_comb
    begin
        trial     = {rem_reg, lo_reg[Q_W-1]};
        take      = (trial >= den);
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            // quotient stays below 2^13, so the upper bits start as remainder
            rem_next  = num[NUM_W-1:Q_W];
            lo_next   = num[Q_W-1:0];
            quo_next  = '0;
            cnt_next  = 4'(Q_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = take ? PX_W'(trial - den) : trial[PX_W-1:0];
            lo_next   = {lo_reg[Q_W-2:0], 1'b0};
            quo_next  = {quo_reg[Q_W-2:0], take};
            cnt_next  = cnt_reg - 4'd1;
            busy_next = (cnt_reg != 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule
`default_nettype wire

FILE: src/box_and_mask_pixel_overlay.sv
// Top level of the box and mask pixel overlay.
//
//  channel  | direction | handshake                  | payload
//  s_axis   | in        | tvalid/tready              | tuser command, tdata item fields
//  m_axis   | out       | tvalid/tready              | tdata out_red, out_green, out_blue
//  cfg      | in        | cfg_we (no wait)           | cfg_addr index, cfg_data value
//
// One item is handled at a time. A pixel's token walks the cell chain one cell a cycle
// from its transfer while two 13-step dividers find the mask column and row; then the
// block forms the mask address, reads the mask RAM and blends. A box computes four corners
// and a track two on one shared multiplier. Reset empties the box and track lists
// and loads register defaults; the mask holds garbage until written. A result waits in the
// output register while the next item is taken; a pixel finished while that register is
// full holds there.
`default_nettype none
module box_and_mask_pixel_overlay
    import bmo_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration write port
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [12:0]  cfg_data,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [2:0]   s_axis_tuser,   // command
    // pixel_x, pixel_y, in_red, in_green, in_blue, center_x, center_y,
    // box_w, box_h, cell_index, cell_class, zero pad
    input  wire logic [135:0] s_axis_tdata,
    // output stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [23:0]  m_axis_tdata    // out_red, out_green, out_blue
);

    // item field positions
    localparam int F_PX  = 0;
    localparam int F_PY  = 11;
    localparam int F_R   = 22;
    localparam int F_G   = 30;
    localparam int F_B   = 38;
    localparam int F_CX  = 46;
    localparam int F_CY  = 62;
    localparam int F_BW  = 78;
    localparam int F_BH  = 94;
    localparam int F_CI  = 110;
    localparam int F_CC  = 122;

    // configuration
    logic [DIM_W-1:0]  fw_reg, fh_reg;
    logic [MDIM_W-1:0] mw_reg, mh_reg;
    logic              db_reg, dm_reg;
    logic [DIM_W-1:0]  w_eff, h_eff;

    // control
    bmo_state_t        state_reg, state_next;
    logic [BCNT_W-1:0] box_cnt_reg;
    logic [TCNT_W-1:0] trk_cnt_reg;
    logic              s_acc;
    logic [2:0]        cmd;
    logic              out_free;

    // corner computation
    logic [15:0]        cx_reg, cy_reg, bw_reg, bh_reg;
    logic               is_box_reg;
    logic [2:0]         step_reg, last_step;
    logic [PROD_W-1:0]  prod_reg;
    logic [DIM_W-1:0]   pdim_reg;
    logic [1:0]         pstep_reg;
    logic               pv_reg;
    logic [COR_W-1:0]   stage_reg [4];
    logic [16:0]        sx, sy;
    logic [MNUM_W-1:0]  lx, rx, ty, by, mnum;
    logic [DIM_W-1:0]   mdim;

    // pixel path
    logic [PX_W-1:0]   px_reg, py_reg;
    logic [7:0]        r_reg, g_reg, b_reg;
    logic              in_frame_reg, red_reg, black_reg, seen_reg, idx_ok_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              div_start, busy_x, busy_y;
    logic [Q_W-1:0]    qx, qy;
    logic [PX_W-1:0]   in_px, in_py;
    logic              chain_end;
    logic [1:0]        cls;
    logic              ram_we;
    logic [7:0]        fr, fg, fb;
    logic              gate;

    // output register
    logic              out_valid_reg;
    logic [23:0]       out_data_reg;

    // cell chain
    bmo_tok_t          tok [NCELL + 1];
    bmo_cellctl_t      ctl [NCELL];
    bmo_ent_t          ent;

    assign cmd    = s_axis_tuser;
    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign in_px  = s_axis_tdata[F_PX +: PX_W];
    assign in_py  = s_axis_tdata[F_PY +: PX_W];
    assign w_eff  = (fw_reg > DIM_MAX) ? DIM_MAX : fw_reg;
    assign h_eff  = (fh_reg > DIM_MAX) ? DIM_MAX : fh_reg;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign chain_end = seen_reg || tok[NCELL].vld;
    assign last_step = is_box_reg ? 3'd4 : 3'd2;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 12'd640;
            fh_reg <= 12'd480;
            mw_reg <= 13'd64;
            mh_reg <= 13'd64;
            db_reg <= 1'b1;
            dm_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FRAME_W:   fw_reg <= cfg_data[DIM_W-1:0];
                REG_FRAME_H:   fh_reg <= cfg_data[DIM_W-1:0];
                REG_MASK_W:    mw_reg <= cfg_data;
                REG_MASK_H:    mh_reg <= cfg_data;
                REG_DRAW_BOX:  db_reg <= cfg_data[0];
                REG_DRAW_MASK: dm_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    case (cmd)
                        CMD_ADD_BOX:
                            if (box_cnt_reg < BCNT_W'(MAX_BOXES))
                                state_next = ST_MUL;
                        CMD_ADD_TRACK:
                            if (trk_cnt_reg < TCNT_W'(MAX_TRACKS))
                                state_next = ST_MUL;
                        CMD_PIXEL:
                            state_next = ST_PIX;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:  if (step_reg == last_step) state_next = ST_WR;
            ST_WR:   state_next = ST_IDLE;
            ST_PIX:  if (chain_end && !busy_x && !busy_y) state_next = ST_IDX;
            ST_IDX:  state_next = ST_RD;
            ST_RD:   state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        div_start     = 1'b0;
        ram_we        = 1'b0;
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            div_start = (cmd == CMD_PIXEL);
            ram_we    = (cmd == CMD_MASK_CELL) &&
                        (32'(s_axis_tdata[F_CI +: 12]) < MASK_CELLS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            box_cnt_reg <= '0;
            trk_cnt_reg <= '0;
            step_reg    <= '0;
            pv_reg      <= 1'b0;
            is_box_reg  <= 1'b0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= (state_reg == ST_MUL) && (step_reg != last_step);
            if (s_acc)
            begin
                step_reg   <= '0;
                is_box_reg <= (cmd == CMD_ADD_BOX);
                seen_reg   <= 1'b0;
                if (cmd == CMD_NEW_FRAME)
                begin
                    box_cnt_reg <= '0;
                    trk_cnt_reg <= '0;
                end
            end
            if (state_reg == ST_MUL)
            begin
                step_reg <= step_reg + 3'd1;
            end
            if (state_reg == ST_WR)
            begin
                if (is_box_reg)
                    box_cnt_reg <= box_cnt_reg + BCNT_W'(1);
                else
                    trk_cnt_reg <= trk_cnt_reg + TCNT_W'(1);
            end
            if (state_reg == ST_PIX && tok[NCELL].vld)
            begin
                seen_reg <= 1'b1;
            end
        end
    end

    // corner numerators in Q1.17
    always_comb
    begin
        sx = {cx_reg, 1'b0};
        sy = {cy_reg, 1'b0};
        lx = (sx >= {1'b0, bw_reg}) ? {1'b0, sx - {1'b0, bw_reg}} : '0;
        rx = {1'b0, sx} + {2'b0, bw_reg};
        ty = (sy >= {1'b0, bh_reg}) ? {1'b0, sy - {1'b0, bh_reg}} : '0;
        by = {1'b0, sy} + {2'b0, bh_reg};
        mnum = {1'b0, sx};
        mdim = w_eff;
        if (is_box_reg)
        begin
            case (step_reg)
                3'd0:    begin mnum = lx; mdim = w_eff; end
                3'd1:    begin mnum = rx; mdim = w_eff; end
                3'd2:    begin mnum = ty; mdim = h_eff; end
                default: begin mnum = by; mdim = h_eff; end
            endcase
        end
        else
        begin
            case (step_reg)
                3'd0:    begin mnum = {1'b0, sx}; mdim = w_eff; end
                default: begin mnum = {1'b0, sy}; mdim = h_eff; end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            cx_reg <= s_axis_tdata[F_CX +: 16];
            cy_reg <= s_axis_tdata[F_CY +: 16];
            bw_reg <= s_axis_tdata[F_BW +: 16];
            bh_reg <= s_axis_tdata[F_BH +: 16];
            px_reg <= in_px;
            py_reg <= in_py;
            r_reg  <= s_axis_tdata[F_R +: 8];
            g_reg  <= s_axis_tdata[F_G +: 8];
            b_reg  <= s_axis_tdata[F_B +: 8];
            in_frame_reg <= ({1'b0, in_px} < w_eff) && ({1'b0, in_py} < h_eff);
        end
        prod_reg  <= PROD_W'(mnum) * PROD_W'(mdim);
        pdim_reg  <= mdim;
        pstep_reg <= step_reg[1:0];
        if (pv_reg)
        begin
            stage_reg[pstep_reg] <= bmo_clamp(prod_reg[PROD_W-1:17], pdim_reg);
        end
        if (state_reg == ST_PIX && tok[NCELL].vld)
        begin
            red_reg   <= tok[NCELL].red;
            black_reg <= tok[NCELL].black;
        end
        if (state_reg == ST_IDX)
        begin
            idx_reg <= IDX_W'(qy) * IDX_W'(mw_reg) + IDX_W'(qx);
        end
        if (state_reg == ST_RD)
        begin
            // drop the blend when the column or row falls outside the mask or the address passes the mask RAM
            idx_ok_reg <= (idx_reg < IDX_W'(MASK_CELLS)) && (qx < mw_reg) && (qy < mh_reg);
        end
    end

    // column and row of the mask cell
    bmo_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (NUM_W'(in_px) * NUM_W'(mw_reg)),
        .den   (w_eff),
        .busy  (busy_x),
        .quot  (qx)
    );

    bmo_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (NUM_W'(in_py) * NUM_W'(mh_reg)),
        .den   (h_eff),
        .busy  (busy_y),
        .quot  (qy)
    );

    // class mask
    bmo_ram #(
        .WIDTH (2),
        .DEPTH (MASK_CELLS)
    ) u_mask (
        .clk   (clk),
        .we    (ram_we),
        .waddr (MASK_AW'(s_axis_tdata[F_CI +: 12])),
        .wdata ((s_axis_tdata[F_CC +: 8] > 8'd2) ? CLS_NONE : s_axis_tdata[F_CC +: 2]),
        .raddr (idx_reg[MASK_AW-1:0]),
        .rdata (cls)
    );

    // inject the pixel token at the head of the chain
    always_comb
    begin
        tok[0].vld   = div_start;
        tok[0].x     = in_px;
        tok[0].y     = in_py;
        tok[0].red   = 1'b0;
        tok[0].black = 1'b0;
        ent.c0 = stage_reg[0];
        ent.c1 = stage_reg[1];
        ent.c2 = stage_reg[2];
        ent.c3 = stage_reg[3];
    end

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        if (i < MAX_BOXES)
        begin : g_box
            assign ctl[i].box_we = (state_reg == ST_WR) && is_box_reg &&
                                   (box_cnt_reg == BCNT_W'(i));
            assign ctl[i].box_on = (box_cnt_reg > BCNT_W'(i));
        end
        else
        begin : g_nobox
            assign ctl[i].box_we = 1'b0;
            assign ctl[i].box_on = 1'b0;
        end
        if (i < MAX_TRACKS)
        begin : g_trk
            assign ctl[i].trk_we = (state_reg == ST_WR) && !is_box_reg &&
                                   (trk_cnt_reg == TCNT_W'(i));
            assign ctl[i].trk_on = (trk_cnt_reg > TCNT_W'(i));
        end
        else
        begin : g_notrk
            assign ctl[i].trk_we = 1'b0;
            assign ctl[i].trk_on = 1'b0;
        end

        bmo_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl[i]),
            .ent     (ent),
            .tok_in  (tok[i]),
            .tok_out (tok[i + 1])
        );
    end

    // final pixel: borders, track squares, then the mask blend
    always_comb
    begin
        gate = db_reg && (box_cnt_reg != '0);
        fr = r_reg;
        fg = g_reg;
        fb = b_reg;
        if (in_frame_reg)
        begin
            if (gate && red_reg)
            begin
                fr = 8'd255;
                fg = 8'd0;
                fb = 8'd0;
            end
            if (gate && black_reg)
            begin
                fr = 8'd0;
                fg = 8'd0;
                fb = 8'd0;
            end
            if (dm_reg && idx_ok_reg)
            begin
                case (cls)
                    CLS_GREEN:
                    begin
                        fr = bmo_blend(fr, 8'd0);
                        fg = bmo_blend(fg, 8'd255);
                        fb = bmo_blend(fb, 8'd0);
                    end
                    CLS_RED:
                    begin
                        fr = bmo_blend(fr, 8'd255);
                        fg = bmo_blend(fg, 8'd0);
                        fb = bmo_blend(fb, 8'd0);
                    end
                    default: ;
                endcase
            end
        end
    end

    // output register: hold until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_data_reg <= {fb, fg, fr};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

FILE: src/bmo_chk.sv
// Port-level checker of the overlay and its bind to the top level.
`default_nettype none
module bmo_chk
    import bmo_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [2:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    logic s_xfer;
    assign s_xfer = s_axis_tvalid && s_axis_tready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no input is taken right after a pixel
    a_pix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && s_axis_tuser == CMD_PIXEL |=> !s_axis_tready)
        else $error("input taken right after a pixel");

    // commands other than pixels never produce a result
    a_cmd_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && s_axis_tuser != CMD_PIXEL && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result without a pixel");

    // a new result appears only as the block returns to idle
    a_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result raised while busy");

endmodule

bind box_and_mask_pixel_overlay bmo_chk u_bmo_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
